// ===== design/tgadec_pkg.sv =====
// Shared types and constants for the TGA stream decoder.
`timescale 1ns / 1ps

package tgadec_pkg;

    typedef enum logic [1:0] {
        KIND_SIZE  = 2'd0,
        KIND_RUN   = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_BAD_TYPE = 2'd1,
        ERR_BAD_DEPTH = 2'd2,
        ERR_CLIPPED  = 2'd3
    } t_err;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_PACKET = 4'b0010,
        PH_PIXEL  = 4'b0100,
        PH_IDLE   = 4'b1000
    } t_phase;

    localparam logic [4:0] HDR_TYPE      = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_DEPTH     = 5'd16;
    localparam logic [4:0] HDR_LAST      = 5'd17;

    localparam logic [7:0] TYPE_RAW = 8'd2;
    localparam logic [7:0] TYPE_RLE = 8'd10;

    localparam logic [4:0] DEPTH_DIV8_RGB  = 5'd3;
    localparam logic [4:0] DEPTH_DIV8_RGBA = 5'd4;

    localparam logic [2:0] BYTES_RGB  = 3'd3;
    localparam logic [2:0] BYTES_RGBA = 3'd4;
    localparam logic [2:0] BYTES_NONE = 3'd0;

endpackage

// ===== design/tgadec_in_if.sv =====
// Byte request channel into the TGA stream decoder.
`timescale 1ns / 1ps

interface tgadec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_of_file;

    modport source (output valid, output data_byte, output first_of_file, input ready);
    modport sink   (input valid, input data_byte, input first_of_file, output ready);
endinterface

// ===== design/tgadec_out_if.sv =====
// Result request channel out of the TGA stream decoder.
`timescale 1ns / 1ps

interface tgadec_out_if;
    logic                valid;
    logic                ready;
    tgadec_pkg::t_kind   kind;
    logic [15:0]         image_width;
    logic [15:0]         image_height;
    logic [7:0]          blue;
    logic [7:0]          green;
    logic [7:0]          red;
    logic [7:0]          alpha;
    logic                has_alpha;
    logic [7:0]          run_length;
    tgadec_pkg::t_err    error_code;
    logic                last;

    modport source (
        output valid, output kind, output image_width, output image_height,
        output blue, output green, output red, output alpha, output has_alpha,
        output run_length, output error_code, output last, input ready
    );
    modport sink (
        input valid, input kind, input image_width, input image_height,
        input blue, input green, input red, input alpha, input has_alpha,
        input run_length, input error_code, input last, output ready
    );
endinterface

// ===== design/tga_image_stream_decoder.sv =====
// TGA stream decoder: header parse, raw or RLE pixel decode and pixel run output.
// Each result is written into the output register as its byte is accepted.
// Throughput: one byte per cycle; a new byte is taken whenever the output register is
// empty or being drained in the same cycle.
// The pixel count (16 x 16 multiply) is formed on the last header byte.
// Synchronous active-low reset clears the parse state and the output valid.
`timescale 1ns / 1ps

module tga_image_stream_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tgadec_in_if.sink          i_in,
    tgadec_out_if.source       o_out
);

    tgadec_pkg::t_phase r_phase, n_phase;
    logic [4:0]  r_hdr_pos, n_hdr_pos;
    logic        r_rle, n_rle;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic [2:0]  r_pbytes, n_pbytes;
    logic [31:0] r_remain, n_remain;
    logic        r_repeat, n_repeat;
    logic [7:0]  r_pkt_left, n_pkt_left;
    logic [1:0]  r_bip, n_bip;
    logic [31:0] r_asm, n_asm;

    logic        r_out_valid;
    tgadec_pkg::t_kind r_kind, n_kind;
    logic [31:0] r_pix, n_pix;
    logic        r_has_alpha, n_has_alpha;
    logic [7:0]  r_run, n_run;
    tgadec_pkg::t_err r_err, n_err;
    logic        r_last, n_last;
    logic [15:0] r_res_w, r_res_h;
    logic        n_res;

    tgadec_pkg::t_phase c_phase;
    logic [4:0]  c_hdr_pos;
    logic        c_rle;
    logic [15:0] c_width, c_height;
    logic [2:0]  c_pbytes;
    logic [31:0] c_remain;
    logic        c_repeat;
    logic [7:0]  c_pkt_left;
    logic [1:0]  c_bip;
    logic [31:0] c_asm;

    logic        w_take;
    logic [7:0]  w_b;
    logic [31:0] w_asm;
    logic [31:0] w_run32;
    logic [7:0]  w_left_dec;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_take     = i_in.valid && i_in.ready;
    assign w_b        = i_in.data_byte;

    always_comb begin
        // a first-of-file byte sees the reset state
        if (i_in.first_of_file) begin
            c_phase    = tgadec_pkg::PH_HEADER;
            c_hdr_pos  = '0;
            c_rle      = 1'b0;
            c_width    = '0;
            c_height   = '0;
            c_pbytes   = tgadec_pkg::BYTES_NONE;
            c_remain   = '0;
            c_repeat   = 1'b0;
            c_pkt_left = '0;
            c_bip      = '0;
            c_asm      = '0;
        end else begin
            c_phase    = r_phase;
            c_hdr_pos  = r_hdr_pos;
            c_rle      = r_rle;
            c_width    = r_width;
            c_height   = r_height;
            c_pbytes   = r_pbytes;
            c_remain   = r_remain;
            c_repeat   = r_repeat;
            c_pkt_left = r_pkt_left;
            c_bip      = r_bip;
            c_asm      = r_asm;
        end

        n_phase    = c_phase;
        n_hdr_pos  = c_hdr_pos;
        n_rle      = c_rle;
        n_width    = c_width;
        n_height   = c_height;
        n_pbytes   = c_pbytes;
        n_remain   = c_remain;
        n_repeat   = c_repeat;
        n_pkt_left = c_pkt_left;
        n_bip      = c_bip;
        n_asm      = c_asm;

        n_res       = 1'b0;
        n_kind      = tgadec_pkg::KIND_ERROR;
        n_pix       = '0;
        n_has_alpha = 1'b0;
        n_run       = '0;
        n_err       = tgadec_pkg::ERR_NONE;
        n_last      = 1'b0;

        w_asm      = c_asm | ({24'b0, w_b} << {c_bip, 3'b000});
        w_run32    = 32'd1;
        w_left_dec = (c_pkt_left != 8'd0) ? c_pkt_left - 8'd1 : 8'd0;

        unique case (c_phase)
            tgadec_pkg::PH_HEADER: begin
                n_hdr_pos = c_hdr_pos + 5'd1;
                unique case (c_hdr_pos)
                    tgadec_pkg::HDR_TYPE: begin
                        if (w_b != tgadec_pkg::TYPE_RAW && w_b != tgadec_pkg::TYPE_RLE) begin
                            n_phase = tgadec_pkg::PH_IDLE;
                            n_res   = 1'b1;
                            n_err   = tgadec_pkg::ERR_BAD_TYPE;
                            n_last  = 1'b1;
                        end
                        n_rle = (w_b == tgadec_pkg::TYPE_RLE);
                    end
                    tgadec_pkg::HDR_WIDTH_LO:  n_width[7:0]   = w_b;
                    tgadec_pkg::HDR_WIDTH_HI:  n_width[15:8]  = w_b;
                    tgadec_pkg::HDR_HEIGHT_LO: n_height[7:0]  = w_b;
                    tgadec_pkg::HDR_HEIGHT_HI: n_height[15:8] = w_b;
                    tgadec_pkg::HDR_DEPTH: begin
                        if (w_b[7:3] == tgadec_pkg::DEPTH_DIV8_RGB) begin
                            n_pbytes = tgadec_pkg::BYTES_RGB;
                        end else if (w_b[7:3] == tgadec_pkg::DEPTH_DIV8_RGBA) begin
                            n_pbytes = tgadec_pkg::BYTES_RGBA;
                        end else begin
                            n_pbytes = tgadec_pkg::BYTES_NONE;
                        end
                    end
                    tgadec_pkg::HDR_LAST: begin
                        n_res  = 1'b1;
                        n_last = 1'b1;
                        if (c_pbytes == tgadec_pkg::BYTES_NONE) begin
                            n_phase = tgadec_pkg::PH_IDLE;
                            n_err   = tgadec_pkg::ERR_BAD_DEPTH;
                        end else begin
                            n_remain    = {16'd0, c_width} * {16'd0, c_height};
                            n_bip       = '0;
                            n_asm       = '0;
                            n_kind      = tgadec_pkg::KIND_SIZE;
                            n_has_alpha = (c_pbytes == tgadec_pkg::BYTES_RGBA);
                            n_last      = (c_width == 16'd0) || (c_height == 16'd0);
                            if (n_last) begin
                                n_phase = tgadec_pkg::PH_IDLE;
                            end else if (c_rle) begin
                                n_phase = tgadec_pkg::PH_PACKET;
                            end else begin
                                n_phase = tgadec_pkg::PH_PIXEL;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            tgadec_pkg::PH_PACKET: begin
                n_repeat   = w_b[7];
                n_pkt_left = w_b[7] ? {1'b0, w_b[6:0]} + 8'd1 : w_b + 8'd1;
                n_bip      = '0;
                n_asm      = '0;
                n_phase    = tgadec_pkg::PH_PIXEL;
            end
            tgadec_pkg::PH_PIXEL: begin
                if ({1'b0, c_bip} + 3'd1 >= c_pbytes) begin
                    n_bip  = '0;
                    n_asm  = '0;
                    n_res  = 1'b1;
                    n_kind = tgadec_pkg::KIND_RUN;
                    n_pix  = w_asm;
                    n_has_alpha = (c_pbytes == tgadec_pkg::BYTES_RGBA);
                    if (c_rle && c_repeat) begin
                        w_run32 = {24'b0, c_pkt_left};
                        if (w_run32 > c_remain) begin
                            w_run32 = c_remain;
                            n_err   = tgadec_pkg::ERR_CLIPPED;
                        end
                        n_remain   = c_remain - w_run32;
                        n_pkt_left = '0;
                        n_phase    = tgadec_pkg::PH_PACKET;
                    end else if (c_rle) begin
                        n_remain   = c_remain - 32'd1;
                        n_pkt_left = w_left_dec;
                        if (n_remain == 32'd0 && w_left_dec != 8'd0) begin
                            n_err = tgadec_pkg::ERR_CLIPPED;
                        end
                        n_phase = (w_left_dec == 8'd0) ? tgadec_pkg::PH_PACKET
                                                       : tgadec_pkg::PH_PIXEL;
                    end else begin
                        n_remain = c_remain - 32'd1;
                        n_phase  = tgadec_pkg::PH_PIXEL;
                    end
                    n_run  = w_run32[7:0];
                    n_last = (n_remain == 32'd0);
                    if (n_last) begin
                        n_phase = tgadec_pkg::PH_IDLE;
                    end
                end else begin
                    n_asm = w_asm;
                    n_bip = c_bip + 2'd1;
                end
            end
            tgadec_pkg::PH_IDLE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= tgadec_pkg::PH_HEADER;
            r_hdr_pos   <= '0;
            r_rle       <= 1'b0;
            r_width     <= '0;
            r_height    <= '0;
            r_pbytes    <= tgadec_pkg::BYTES_NONE;
            r_remain    <= '0;
            r_repeat    <= 1'b0;
            r_pkt_left  <= '0;
            r_bip       <= '0;
            r_asm       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_phase     <= n_phase;
                r_hdr_pos   <= n_hdr_pos;
                r_rle       <= n_rle;
                r_width     <= n_width;
                r_height    <= n_height;
                r_pbytes    <= n_pbytes;
                r_remain    <= n_remain;
                r_repeat    <= n_repeat;
                r_pkt_left  <= n_pkt_left;
                r_bip       <= n_bip;
                r_asm       <= n_asm;
                r_out_valid <= n_res;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && n_res) begin
            r_kind      <= n_kind;
            r_pix       <= n_pix;
            r_has_alpha <= n_has_alpha;
            r_run       <= n_run;
            r_err       <= n_err;
            r_last      <= n_last;
            r_res_w     <= n_width;
            r_res_h     <= n_height;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_kind;
    assign o_out.image_width  = r_res_w;
    assign o_out.image_height = r_res_h;
    assign o_out.blue         = r_pix[7:0];
    assign o_out.green        = r_pix[15:8];
    assign o_out.red          = r_pix[23:16];
    assign o_out.alpha        = r_pix[31:24];
    assign o_out.has_alpha    = r_has_alpha;
    assign o_out.run_length   = r_run;
    assign o_out.error_code   = r_err;
    assign o_out.last         = r_last;

endmodule
